### sv/tep_pkg.sv
`default_nettype none

package tep_pkg;

    // Byte codes recognized by the parser
    localparam logic [7:0] C_ESC      = 8'd27;
    localparam logic [7:0] C_NEWLINE  = 8'd10;
    localparam logic [7:0] C_LBRACKET = 8'h5b;
    localparam logic [7:0] C_SEMI     = 8'h3b;
    localparam logic [7:0] C_LOWER_M  = 8'h6d;

    // Number of result words one input byte can cause
    localparam int MaxResults = 3;

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_OPEN   = 2'd1,
        MODE_DIGITS = 2'd2,
        MODE_LETTER = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_BREAK = 2'd1,
        KIND_EVENT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        logic [15:0] row;
        logic [15:0] column;
    } t_result;

    // Results of one byte, in delivery order from entry 0
    typedef struct packed {
        logic [1:0]                  count;
        t_result [MaxResults-1:0]    entries;
    } t_result_list;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    endfunction

endpackage

`default_nettype wire

### sv/tep_in_if.sv
`default_nettype none

interface tep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

### sv/tep_out_if.sv
`default_nettype none

interface tep_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] row;
    logic [15:0] column;
    logic        last;

    modport source (output valid, output kind, output out_byte, output row,
                    output column, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input row,
                    input column, input last, output ready);
endinterface

`default_nettype wire

### sv/tep_parser.sv
`default_nettype none

module tep_parser import tep_pkg::*; #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_step,
    input  wire logic [7:0]   i_byte,
    output t_result_list      o_list
);

    localparam int OutW = (VALUE_WIDTH < 16) ? VALUE_WIDTH : 16;

    t_mode                  r_mode, n_mode;
    logic [VALUE_WIDTH-1:0] r_first, n_first;
    logic [VALUE_WIDTH-1:0] r_second, n_second;
    logic                   r_first_open, n_first_open;
    logic                   r_second_open, n_second_open;
    logic                   r_sep, n_sep;
    logic                   r_color, n_color;
    logic [VALUE_WIDTH-1:0] r_last_row, n_last_row;
    logic                   r_last_row_valid, n_last_row_valid;

    // v*10 + digit, saturating at all ones
    function automatic logic [VALUE_WIDTH-1:0] add_digit(
        input logic [VALUE_WIDTH-1:0] v,
        input logic [7:0]             c
    );
        logic [VALUE_WIDTH+3:0] wide;
        wide = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (VALUE_WIDTH+4)'(c[3:0]);
        if (|wide[VALUE_WIDTH+3:VALUE_WIDTH]) begin
            return '1;
        end
        return wide[VALUE_WIDTH-1:0];
    endfunction

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= MODE_TEXT;
            r_first          <= '0;
            r_second         <= '0;
            r_first_open     <= 1'b1;
            r_second_open    <= 1'b1;
            r_sep            <= 1'b0;
            r_color          <= 1'b0;
            r_last_row       <= '0;
            r_last_row_valid <= 1'b0;
        end else if (i_step) begin
            r_mode           <= n_mode;
            r_first          <= n_first;
            r_second         <= n_second;
            r_first_open     <= n_first_open;
            r_second_open    <= n_second_open;
            r_sep            <= n_sep;
            r_color          <= n_color;
            r_last_row       <= n_last_row;
            r_last_row_valid <= n_last_row_valid;
        end
    end

    // Next state and result list for the byte at the input
    always_comb begin
        logic       take;
        logic [1:0] cnt;

        n_mode           = r_mode;
        n_first          = r_first;
        n_second         = r_second;
        n_first_open     = r_first_open;
        n_second_open    = r_second_open;
        n_sep            = r_sep;
        n_color          = r_color;
        n_last_row       = r_last_row;
        n_last_row_valid = r_last_row_valid;
        o_list           = '0;
        cnt              = 2'd0;

        // sequence byte: update field accumulators
        take = (r_mode == MODE_OPEN) || (r_mode == MODE_DIGITS) ||
               ((r_mode == MODE_LETTER) && (i_byte == C_SEMI));
        if (take) begin
            if (!r_sep) begin
                if (i_byte == C_SEMI) begin
                    n_sep = 1'b1;
                end else if (r_first_open && is_digit(i_byte)) begin
                    n_first = add_digit(r_first, i_byte);
                end else begin
                    n_first_open = 1'b0;
                end
            end else begin
                if (r_second_open && is_digit(i_byte)) begin
                    n_second = add_digit(r_second, i_byte);
                end else begin
                    n_second_open = 1'b0;
                end
            end
        end

        case (r_mode)
            MODE_TEXT: begin
                if (i_byte == C_LBRACKET) begin
                    n_mode = MODE_OPEN;
                end else if (i_byte == C_ESC) begin
                    o_list.entries[cnt].kind = KIND_BREAK;
                    cnt = cnt + 2'd1;
                end else begin
                    o_list.entries[cnt].kind     = KIND_TEXT;
                    o_list.entries[cnt].out_byte = i_byte;
                    cnt = cnt + 2'd1;
                end
            end
            MODE_OPEN: begin
                if (is_digit(i_byte)) begin
                    n_mode = MODE_DIGITS;
                end else if (is_letter(i_byte)) begin
                    n_mode  = MODE_LETTER;
                    n_color = (i_byte == C_LOWER_M);
                end
            end
            MODE_DIGITS: begin
                if (is_letter(i_byte)) begin
                    n_mode  = MODE_LETTER;
                    n_color = (i_byte == C_LOWER_M);
                end else if (i_byte == C_SEMI) begin
                    n_mode = MODE_OPEN;
                end
            end
            default: begin
                // letter seen: this byte closes the sequence unless it is ';'
                if (i_byte == C_SEMI) begin
                    n_mode = MODE_OPEN;
                end else begin
                    if (!r_color && r_sep) begin
                        o_list.entries[cnt].kind   = KIND_EVENT;
                        o_list.entries[cnt].row    = 16'(r_first[OutW-1:0]);
                        o_list.entries[cnt].column = 16'(r_second[OutW-1:0]);
                        cnt = cnt + 2'd1;
                        if (!r_last_row_valid || (r_first != r_last_row)) begin
                            n_last_row       = r_first;
                            n_last_row_valid = 1'b1;
                            o_list.entries[cnt].kind = KIND_BREAK;
                            cnt = cnt + 2'd1;
                        end
                    end
                    n_first       = '0;
                    n_second      = '0;
                    n_first_open  = 1'b1;
                    n_second_open = 1'b1;
                    n_sep         = 1'b0;
                    n_color       = 1'b0;
                    n_mode        = MODE_TEXT;
                    // closing byte re-enters text handling; ESC and LF dropped
                    if ((i_byte != C_ESC) && (i_byte != C_NEWLINE)) begin
                        if (i_byte == C_LBRACKET) begin
                            n_mode = MODE_OPEN;
                        end else begin
                            o_list.entries[cnt].kind     = KIND_TEXT;
                            o_list.entries[cnt].out_byte = i_byte;
                            cnt = cnt + 2'd1;
                        end
                    end
                end
            end
        endcase

        o_list.count = cnt;
    end

endmodule

`default_nettype wire

### sv/tep_result_buf.sv
`default_nettype none

module tep_result_buf import tep_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire t_result_list  i_list,
    output logic               o_free,
    tep_out_if.source          o_out
);

    t_result [MaxResults-1:0] r_entries;
    logic [1:0]               r_cnt;
    logic [1:0]               r_idx;
    logic                     pop;
    logic                     at_last;

    assign pop     = o_out.valid && o_out.ready;
    assign at_last = (r_idx == (r_cnt - 2'd1));
    // empty next cycle, so a new list may be loaded
    assign o_free  = (r_cnt == 2'd0) || (pop && at_last);

    // Read pointer and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_list.count;
            r_idx <= 2'd0;
        end else if (pop) begin
            if (at_last) begin
                r_cnt <= 2'd0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entries <= i_list.entries;
        end
    end

    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.kind     = r_entries[r_idx].kind;
    assign o_out.out_byte = r_entries[r_idx].out_byte;
    assign o_out.row      = r_entries[r_idx].row;
    assign o_out.column   = r_entries[r_idx].column;
    assign o_out.last     = at_last;

endmodule

`default_nettype wire

### sv/terminal_escape_position_parser.sv
// Terminal escape-sequence position parser.
// Accepted bytes pass the input register, then the result buffer on the output.
// Throughput: one byte per cycle while each byte gives at most one word and o_out
// is ready; a byte giving more holds the buffer, one word per cycle while ready.
// Reset (synchronous, active low): text mode, sequence fields cleared, no row kept.
`default_nettype none

module terminal_escape_position_parser import tep_pkg::*; #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tep_in_if.sink     i_in,
    tep_out_if.source  o_out
);

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         buf_free;
    logic         step;
    t_result_list list;

    assign step       = r_in_valid && buf_free;
    assign i_in.ready = !r_in_valid || buf_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    tep_parser #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_list  (list)
    );

    tep_result_buf u_result_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_list  (list),
        .o_free  (buf_free),
        .o_out   (o_out)
    );

    // A parsed byte shows its words on the next cycle exactly when it has any
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> (o_out.valid == ($past(list.count) != 2'd0)))
        else $error("result buffer valid does not follow loaded count");

    // A word that is not the last of its byte is followed by another
    a_burst_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> o_out.valid)
        else $error("result burst ended early");

    // Position fields only carry data on events
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind != KIND_EVENT)) |->
            ((o_out.row == 16'd0) && (o_out.column == 16'd0)))
        else $error("position fields set on a non-event word");

    // Text byte field only carries data on text words
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind != KIND_TEXT)) |-> (o_out.out_byte == 8'd0))
        else $error("byte field set on a non-text word");

endmodule

`default_nettype wire

### sim/terminal_escape_position_parser_test.sv
module terminal_escape_position_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tep_pkg::*;

    localparam int unsigned VALUE_MAX   = 65535;
    localparam int          STREAM_LEN  = 310;
    localparam int          CYCLE_LIMIT = 150000;
    localparam int          SETTLE_WAIT = 20;
    localparam int          HOLD_CYCLES = 300;
    localparam int          PRINT_CAP   = 40;

    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_NINE    = "9";
    localparam logic [7:0] CH_UPPER_A = "A";
    localparam logic [7:0] CH_UPPER_Z = "Z";
    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] CH_LOWER_Z = "z";
    localparam logic [7:0] CH_QUERY   = "?";
    localparam logic [7:0] CH_CUP     = "H";
    localparam logic [7:0] CH_SPACE   = " ";
    localparam logic [7:0] CH_MINUS   = "-";

    // one word on the result channel, as the parser should deliver it
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        logic [15:0] row;
        logic [15:0] column;
        logic        last;
    } t_screen_word;

    typedef struct {
        logic [7:0] data;
        bit         drain_before;
    } t_term_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tep_in_if  byte_bus ();
    tep_out_if word_bus ();

    terminal_escape_position_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_bus),
        .o_out   (word_bus)
    );

    always #5 i_clk = ~i_clk;

    t_term_item   term_bytes[$];
    t_screen_word expected_words[$];

    int error_count    = 0;
    int bytes_accepted = 0;
    int words_checked  = 0;
    int text_words     = 0;
    int break_words    = 0;
    int cursor_words   = 0;
    int cycle_count    = 0;

    // parser state mirror
    t_mode       seq_mode       = MODE_TEXT;
    int unsigned row_acc        = 0;
    int unsigned col_acc        = 0;
    bit          row_open       = 1'b1;
    bit          col_open       = 1'b1;
    bit          semi_seen      = 1'b0;
    bit          color_final    = 1'b0;
    logic [15:0] kept_row       = '0;
    bit          kept_row_valid = 1'b0;

    function automatic bit digit_char(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit letter_char(logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
    endfunction

    function automatic int unsigned add_digit(int unsigned v, logic [7:0] c);
        int unsigned n;
        n = v * 10 + (c - CH_ZERO);
        return (n > VALUE_MAX) ? VALUE_MAX : n;
    endfunction

    function automatic void expect_word(t_kind k, logic [7:0] b, logic [15:0] r, logic [15:0] col);
        expected_words.push_back('{kind: k, out_byte: b, row: r, column: col, last: 1'b0});
    endfunction

    // fold one sequence byte into the row/column accumulators
    function automatic void absorb(logic [7:0] c);
        if (!semi_seen) begin
            if (c == C_SEMI)
                semi_seen = 1'b1;
            else if (row_open && digit_char(c))
                row_acc = add_digit(row_acc, c);
            else
                row_open = 1'b0;
        end else begin
            if (col_open && digit_char(c))
                col_acc = add_digit(col_acc, c);
            else
                col_open = 1'b0;
        end
    endfunction

    function automatic void text_mode_byte(logic [7:0] c);
        if (c == C_LBRACKET)
            seq_mode = MODE_OPEN;
        else if (c == C_ESC)
            expect_word(KIND_BREAK, '0, '0, '0);
        else
            expect_word(KIND_TEXT, c, '0, '0);
    endfunction

    // predict the words caused by one accepted byte
    function automatic void parse_byte(logic [7:0] c);
        int queued_before;
        queued_before = expected_words.size();
        case (seq_mode)
            MODE_TEXT: begin
                text_mode_byte(c);
            end
            MODE_OPEN: begin
                absorb(c);
                if (digit_char(c)) begin
                    seq_mode = MODE_DIGITS;
                end else if (letter_char(c)) begin
                    seq_mode    = MODE_LETTER;
                    color_final = (c == C_LOWER_M);
                end
            end
            MODE_DIGITS: begin
                absorb(c);
                if (letter_char(c)) begin
                    seq_mode    = MODE_LETTER;
                    color_final = (c == C_LOWER_M);
                end else if (c == C_SEMI) begin
                    seq_mode = MODE_OPEN;
                end
            end
            default: begin
                if (c == C_SEMI) begin
                    absorb(c);
                    seq_mode = MODE_OPEN;
                end else begin
                    if (!color_final && semi_seen) begin
                        expect_word(KIND_EVENT, '0, row_acc[15:0], col_acc[15:0]);
                        if (!kept_row_valid || row_acc[15:0] != kept_row) begin
                            kept_row       = row_acc[15:0];
                            kept_row_valid = 1'b1;
                            expect_word(KIND_BREAK, '0, '0, '0);
                        end
                    end
                    row_acc     = 0;
                    col_acc     = 0;
                    row_open    = 1'b1;
                    col_open    = 1'b1;
                    semi_seen   = 1'b0;
                    color_final = 1'b0;
                    seq_mode    = MODE_TEXT;
                    // closing byte: ESC and newline are swallowed
                    if (c != C_ESC && c != C_NEWLINE)
                        text_mode_byte(c);
                end
            end
        endcase
        if (expected_words.size() > queued_before)
            expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    task automatic flag_mismatch(string what);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // stimulus building
    function automatic void queue_byte(logic [7:0] b);
        term_bytes.push_back('{data: b, drain_before: 1'b0});
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endfunction

    // one numeric field: empty, small (row repeats), medium, overlong, or junk-led
    function automatic void queue_field();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return;
        end else if (pick <= 4) begin
            queue_text($sformatf("%0d", $urandom_range(0, 3)));
        end else if (pick <= 6) begin
            queue_text($sformatf("%0d", $urandom_range(0, 999)));
        end else if (pick == 7) begin
            queue_text($sformatf("%0d%0d", $urandom_range(6, 99), $urandom_range(1000, 99999)));
        end else begin
            queue_byte(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_MINUS);
            queue_text($sformatf("%0d", $urandom_range(0, 99)));
        end
    endfunction

    function automatic void queue_sequence();
        int unsigned pick;
        queue_byte(C_LBRACKET);
        if ($urandom_range(0, 4) == 0)
            queue_byte(CH_QUERY);
        queue_field();
        if ($urandom_range(0, 5) != 0) begin
            queue_byte(C_SEMI);
            queue_field();
            if ($urandom_range(0, 7) == 0) begin
                queue_byte(C_SEMI);
                queue_field();
            end
        end
        if ($urandom_range(0, 9) == 0)
            queue_byte(8'($urandom_range(0, 255)));
        // final letter
        pick = $urandom_range(0, 9);
        if (pick <= 1)
            queue_byte(C_LOWER_M);
        else if (pick <= 5)
            queue_byte(CH_CUP);
        else if (pick <= 7)
            queue_byte(CH_UPPER_A + 8'($urandom_range(0, 25)));
        else
            queue_byte(CH_LOWER_A + 8'($urandom_range(0, 25)));
        // closing byte
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1:    queue_byte(C_ESC);
            2:       queue_byte(C_NEWLINE);
            3:       queue_byte(C_LBRACKET);
            4:       queue_byte(C_SEMI);
            default: queue_byte(8'($urandom_range(0, 255)));
        endcase
    endfunction

    // byte driver: bursts and gaps, holds a byte until taken
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        logic       next_valid;
        logic [7:0] next_byte;
        if (!i_rst_n) begin
            byte_bus.valid   <= 1'b0;
            byte_bus.in_byte <= '0;
        end else begin
            next_valid = 1'b0;
            next_byte  = byte_bus.in_byte;
            if (byte_bus.valid && byte_bus.ready) begin
                parse_byte(term_bytes[0].data);
                void'(term_bytes.pop_front());
                bytes_accepted++;
            end
            if (byte_bus.valid && !byte_bus.ready) begin
                next_valid = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (term_bytes.size() != 0 &&
                         !(term_bytes[0].drain_before && expected_words.size() != 0)) begin
                next_valid = 1'b1;
                next_byte  = term_bytes[0].data;
                if (burst_left > 0) begin
                    burst_left--;
                end else if ($urandom_range(0, 4) == 0) begin
                    burst_left = $urandom_range(50, 120);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(0, 10);
                    gap_left   = $urandom_range(0, 6);
                end
            end
            byte_bus.valid   <= next_valid;
            byte_bus.in_byte <= next_byte;
        end
    end

    // result sink: stall styles per phase, plus one long hold-off
    int hold_left     = 0;
    bit long_hold_done = 1'b0;
    int phase_left    = 0;
    int stall_style   = 0;

    always @(posedge i_clk) begin
        logic next_ready;
        if (!i_rst_n) begin
            word_bus.ready <= 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (!long_hold_done && bytes_accepted >= 100) begin
                long_hold_done = 1'b1;
                hold_left      = HOLD_CYCLES;
                next_ready     = 1'b0;
            end else begin
                if (phase_left == 0) begin
                    stall_style = $urandom_range(0, 3);
                    phase_left  = $urandom_range(5, 40);
                end else begin
                    phase_left--;
                end
                case (stall_style)
                    0:       next_ready = 1'b1;
                    1:       next_ready = ($urandom_range(0, 1) != 0);
                    2:       next_ready = ($urandom_range(0, 3) != 0);
                    default: next_ready = ((phase_left % 4) == 0);
                endcase
            end
            word_bus.ready <= next_ready;
        end
    end

    // word checker
    always @(posedge i_clk) begin
        t_screen_word want;
        if (i_rst_n && word_bus.valid && word_bus.ready) begin
            if (expected_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected word kind %0d byte %02h row %0d col %0d",
                    word_bus.kind, word_bus.out_byte, word_bus.row, word_bus.column));
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                case (want.kind)
                    KIND_TEXT:  text_words++;
                    KIND_BREAK: break_words++;
                    default:    cursor_words++;
                endcase
                if (word_bus.kind != want.kind)
                    flag_mismatch($sformatf("word %0d kind %0d, want %0d",
                        words_checked, word_bus.kind, want.kind));
                if (word_bus.out_byte != want.out_byte)
                    flag_mismatch($sformatf("word %0d byte %02h, want %02h",
                        words_checked, word_bus.out_byte, want.out_byte));
                if (word_bus.row != want.row)
                    flag_mismatch($sformatf("word %0d row %0d, want %0d",
                        words_checked, word_bus.row, want.row));
                if (word_bus.column != want.column)
                    flag_mismatch($sformatf("word %0d column %0d, want %0d",
                        words_checked, word_bus.column, want.column));
                if (word_bus.last != want.last)
                    flag_mismatch($sformatf("word %0d last %0b, want %0b",
                        words_checked, word_bus.last, want.last));
            end
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycle_count,
                expected_words.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int drain_mark;
        i_rst_n          = 1'b0;
        byte_bus.valid   = 1'b0;
        byte_bus.in_byte = '0;
        word_bus.ready   = 1'b0;

        // directed: byte extremes, ESC, '?' prefix, saturation, '[' as closer,
        // color sequence with ESC closer, same row twice with newline closer
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(C_ESC);
        queue_text("[?12;99999H[");
        queue_text("7;3m");
        queue_byte(C_ESC);
        queue_text("[0;5H");
        queue_byte(C_NEWLINE);

        // random: mostly well-formed sequences, text between, some raw noise
        drain_mark = term_bytes.size();
        while (term_bytes.size() < STREAM_LEN) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(3, 10)) queue_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(0, 4)) queue_byte(8'($urandom_range(0, 255)));
                queue_sequence();
            end
        end
        term_bytes[drain_mark].drain_before = 1'b1;
        term_bytes[180].drain_before        = 1'b1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (term_bytes.size() != 0 || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("covered %0d input bytes and %0d result words", bytes_accepted, words_checked);
        $display("  %0d text, %0d line breaks, %0d cursor positions", text_words, break_words,
            cursor_words);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### terminal_escape_position_parser.f
sv/tep_pkg.sv
sv/tep_in_if.sv
sv/tep_out_if.sv
sv/tep_parser.sv
sv/tep_result_buf.sv
sv/terminal_escape_position_parser.sv
sim/terminal_escape_position_parser_test.sv
